/* design/assert_macros.svh */
// Assertion macros used by the top level of the rate combiner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/ptrc_pkg.sv */
// Shared types, constants and constant functions of the rate combiner.
`default_nettype none
package ptrc_pkg;
    localparam int ENERGY_W    = 19;
    localparam int DELTA_W     = ENERGY_W + 1;
    localparam int KT_W        = 32;
    localparam int FRAC_W      = 32;
    localparam int RATE_W      = 33;
    localparam int SUM_W       = 34;
    localparam int X_W         = ENERGY_W + KT_W;
    localparam int PROD_W      = 2 * RATE_W;
    localparam int DIVISOR_W   = 34;
    localparam int K_W         = 5;
    localparam int N_W         = 5;
    localparam int TAYLOR_TERMS = 24;
    localparam int DIV_RADIX_BITS = 3;
    localparam int DIV_STEPS   = RATE_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int E1_W        = 31;

    localparam logic [KT_W-1:0]   INV_KT_RESET = 32'd69677255;
    localparam logic [RATE_W-1:0] ONE_Q32      = 33'h1_0000_0000;
    localparam logic [K_W-1:0]    K_LAST       = 5'(TAYLOR_TERMS);

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic               first;
        logic               last;
    } t_item;

    typedef struct packed {
        logic                 start;
        logic [PROD_W-1:0]    dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } t_div_rsp;

    // exp(-1) in Q32, as the square of the series value at one half.
    function automatic logic [63:0] f_exp_minus_one();
        logic [63:0] term;
        logic [63:0] even;
        logic [63:0] odd;
        logic [63:0] h;
        term = 64'h1_0000_0000;
        even = term;
        odd  = 64'd0;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * 64'h8000_0000) >> 32) / 64'(k);
            if ((k % 2) == 1) odd = odd + term;
            else              even = even + term;
        end
        h = (even >= odd) ? (even - odd) : 64'd0;
        return (h * h) >> 32;
    endfunction

    localparam logic [63:0]     E1_FULL = f_exp_minus_one();
    localparam logic [E1_W-1:0] E1      = E1_FULL[E1_W-1:0];
endpackage
`default_nettype wire

/* design/ptrc_front.sv */
// Front end: accepts path points and turns them into step items.
`default_nettype none
module ptrc_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [ptrc_pkg::ENERGY_W-1:0] i_energy,
    input  wire logic                                i_first,
    input  wire logic                                i_last,
    input  wire logic                                i_q_full,
    output logic                                     o_q_push,
    output ptrc_pkg::t_item                          o_q_item
);
    logic [ptrc_pkg::ENERGY_W-1:0] r_prev;
    logic [ptrc_pkg::ENERGY_W-1:0] n_prev;

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && o_ready;

    always_comb begin
        o_q_item.delta = {i_energy[ptrc_pkg::ENERGY_W-1], i_energy}
                       - {r_prev[ptrc_pkg::ENERGY_W-1], r_prev};
        o_q_item.first = i_first;
        o_q_item.last  = i_last;
        n_prev = o_q_push ? i_energy : r_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end
endmodule
`default_nettype wire

/* design/ptrc_queue.sv */
// Short item queue between front end and back end.
`default_nettype none
module ptrc_queue #(
    parameter int DEPTH = ptrc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ptrc_pkg::t_item i_item,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output ptrc_pkg::t_item      o_item
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ptrc_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* design/ptrc_div.sv */
// Shared restoring divider, a few quotient bits per cycle.
`default_nettype none
module ptrc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ptrc_pkg::t_div_req i_req,
    output ptrc_pkg::t_div_rsp      o_rsp
);
    localparam int QW = ptrc_pkg::RATE_W;
    localparam int DW = ptrc_pkg::DIVISOR_W;

    logic [DW-1:0]                   r_rem;
    logic [QW-1:0]                   r_low;
    logic [QW-1:0]                   r_quo;
    logic [DW-1:0]                   r_div;
    logic [ptrc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [DW-1:0]                   n_rem;
    logic [QW-1:0]                   n_low;
    logic [QW-1:0]                   n_quo;

    always_comb begin
        logic [DW:0] rem;
        rem   = {1'b0, r_rem};
        n_low = r_low;
        n_quo = r_quo;
        for (int i = 0; i < ptrc_pkg::DIV_RADIX_BITS; i++) begin
            rem   = {rem[DW-1:0], n_low[QW-1]};
            n_low = {n_low[QW-2:0], 1'b0};
            if (rem >= {1'b0, r_div}) begin
                rem   = rem - {1'b0, r_div};
                n_quo = {n_quo[QW-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[QW-2:0], 1'b0};
            end
        end
        n_rem = rem[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= {1'b0, i_req.dividend[2*QW-1:QW]};
                r_low  <= i_req.dividend[QW-1:0];
                r_quo  <= '0;
                r_div  <= i_req.divisor;
                r_cnt  <= ptrc_pkg::DIV_CNT_W'(ptrc_pkg::DIV_STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_low <= n_low;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ptrc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

/* design/ptrc_back.sv */
// Back end: Metropolis rates per step, rate folding and result register.
`default_nettype none
module ptrc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ptrc_pkg::KT_W-1:0]     i_inv_kt,
    input  wire logic                          i_q_valid,
    input  wire ptrc_pkg::t_item               i_q_item,
    output logic                               o_q_pop,
    output ptrc_pkg::t_div_req                 o_div_req,
    input  wire ptrc_pkg::t_div_rsp            i_div_rsp,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ptrc_pkg::RATE_W-1:0]        o_rate_up,
    output logic [ptrc_pkg::RATE_W-1:0]        o_rate_down,
    output logic                               o_single_point
);
    localparam int RW = ptrc_pkg::RATE_W;
    localparam int XW = ptrc_pkg::X_W;
    localparam int PW = ptrc_pkg::PROD_W;
    localparam int SW = ptrc_pkg::SUM_W;
    localparam int EW = ptrc_pkg::ENERGY_W;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_EXPINIT, S_TMUL, S_TSTART, S_TDIV, S_EXPSUB, S_E1,
        S_SET, S_COMB, S_MU, S_DUST, S_DUW, S_MD, S_DDST, S_DDW, S_FIN
    } t_state;

    t_state                       r_state;
    ptrc_pkg::t_item              r_item;
    logic [XW-1:0]                r_x;
    logic [ptrc_pkg::FRAC_W-1:0]  r_term;
    logic [ptrc_pkg::K_W-1:0]     r_k;
    logic [SW-1:0]                r_even;
    logic [SW-1:0]                r_odd;
    logic [ptrc_pkg::N_W-1:0]     r_n;
    logic [RW-1:0]                r_e;
    logic [RW-1:0]                r_ru;
    logic [RW-1:0]                r_rd;
    logic [RW-1:0]                r_acc_up;
    logic [RW-1:0]                r_acc_down;
    logic                         r_has_step;
    logic [ptrc_pkg::DIVISOR_W-1:0] r_d;
    logic [PW-1:0]                r_prod;
    logic [RW-1:0]                r_nu;
    logic                         r_out_valid;
    logic [RW-1:0]                r_out_up;
    logic [RW-1:0]                r_out_down;
    logic                         r_out_single;

    logic [ptrc_pkg::DELTA_W-1:0] mag_full;
    logic [EW-1:0]                mag;
    logic [63:0]                  tprod;
    logic [63:0]                  eprod;
    logic [ptrc_pkg::DIVISOR_W-1:0] d_sum;
    logic                         emit;

    always_comb begin
        mag_full = r_item.delta[ptrc_pkg::DELTA_W-1] ? ('0 - r_item.delta) : r_item.delta;
        mag      = mag_full[EW-1:0];
        tprod    = 64'(r_term) * 64'(r_x[ptrc_pkg::FRAC_W-1:0]);
        eprod    = 64'(r_e) * 64'(ptrc_pkg::E1);
        d_sum    = {1'b0, r_acc_down} + {1'b0, r_ru};
    end

    // Load a new result when the register is free or being drained this cycle.
    assign emit = (r_state == S_FIN) && r_item.last && (!r_out_valid || i_ready);

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        o_div_req.start    = (r_state == S_TSTART) || (r_state == S_DUST) ||
                             (r_state == S_DDST);
        o_div_req.dividend = r_prod;
        o_div_req.divisor  = (r_state == S_TSTART) ?
                             ptrc_pkg::DIVISOR_W'(r_k) : r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_up    <= '0;
            r_acc_down  <= '0;
            r_has_step  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_item.first) begin
                        r_acc_up   <= '0;
                        r_acc_down <= '0;
                        r_has_step <= 1'b0;
                        r_state    <= S_FIN;
                    end else if (r_item.delta == '0) begin
                        r_ru    <= ptrc_pkg::ONE_Q32;
                        r_rd    <= ptrc_pkg::ONE_Q32;
                        r_state <= S_COMB;
                    end else begin
                        r_x     <= XW'(mag) * XW'(i_inv_kt);
                        r_state <= S_EXPINIT;
                    end
                end
                S_EXPINIT: begin
                    // Integer part of 32 or more: the rate underflows.
                    if (|r_x[XW-1:ptrc_pkg::FRAC_W+ptrc_pkg::N_W]) begin
                        r_e     <= '0;
                        r_state <= S_SET;
                    end else begin
                        r_term  <= r_x[ptrc_pkg::FRAC_W-1:0];
                        r_even  <= SW'(ptrc_pkg::ONE_Q32);
                        r_odd   <= SW'(r_x[ptrc_pkg::FRAC_W-1:0]);
                        r_k     <= ptrc_pkg::K_W'(2);
                        r_n     <= r_x[ptrc_pkg::FRAC_W+ptrc_pkg::N_W-1:ptrc_pkg::FRAC_W];
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_prod  <= PW'(tprod[63:32]);
                    r_state <= S_TSTART;
                end
                S_TSTART: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (i_div_rsp.done) begin
                        r_term <= i_div_rsp.quotient[ptrc_pkg::FRAC_W-1:0];
                        if (r_k[0]) r_odd  <= r_odd + SW'(i_div_rsp.quotient);
                        else        r_even <= r_even + SW'(i_div_rsp.quotient);
                        r_k     <= r_k + 1'b1;
                        r_state <= (r_k == ptrc_pkg::K_LAST) ? S_EXPSUB : S_TMUL;
                    end
                end
                S_EXPSUB: begin
                    r_e     <= (r_even >= r_odd) ? RW'(r_even - r_odd) : '0;
                    r_state <= S_E1;
                end
                S_E1: begin
                    if (r_n == '0) begin
                        r_state <= S_SET;
                    end else begin
                        r_e <= RW'(eprod[63:32]);
                        r_n <= r_n - 1'b1;
                    end
                end
                S_SET: begin
                    if (r_item.delta[ptrc_pkg::DELTA_W-1]) begin
                        r_ru <= ptrc_pkg::ONE_Q32;
                        r_rd <= r_e;
                    end else begin
                        r_ru <= r_e;
                        r_rd <= ptrc_pkg::ONE_Q32;
                    end
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (!r_has_step) begin
                        r_acc_up   <= r_ru;
                        r_acc_down <= r_rd;
                        r_has_step <= 1'b1;
                        r_state    <= S_FIN;
                    end else if (d_sum == '0) begin
                        r_acc_up   <= '0;
                        r_acc_down <= '0;
                        r_state    <= S_FIN;
                    end else begin
                        r_d     <= d_sum;
                        r_state <= S_MU;
                    end
                end
                S_MU: begin
                    r_prod  <= PW'(r_acc_up) * PW'(r_ru);
                    r_state <= S_DUST;
                end
                S_DUST: begin
                    r_state <= S_DUW;
                end
                S_DUW: begin
                    if (i_div_rsp.done) begin
                        r_nu    <= i_div_rsp.quotient;
                        r_state <= S_MD;
                    end
                end
                S_MD: begin
                    r_prod  <= PW'(r_acc_down) * PW'(r_rd);
                    r_state <= S_DDST;
                end
                S_DDST: begin
                    r_state <= S_DDW;
                end
                S_DDW: begin
                    if (i_div_rsp.done) begin
                        r_acc_up   <= r_nu;
                        r_acc_down <= i_div_rsp.quotient;
                        r_state    <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_item.last) begin
                        r_state <= S_IDLE;
                    end else if (emit) begin
                        r_out_valid  <= 1'b1;
                        r_out_up     <= r_has_step ? r_acc_up : '0;
                        r_out_down   <= r_has_step ? r_acc_down : '0;
                        r_out_single <= !r_has_step;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rate_up      = r_out_up;
    assign o_rate_down    = r_out_down;
    assign o_single_point = r_out_single;
endmodule
`default_nettype wire

/* design/path_transition_rate_combiner.sv */
// Top level of the path transition rate combiner.
//
// Usage: feed the energies of a folding path, one point per transfer on the
// input channel (i_valid/o_ready), with i_first on the first point and
// i_last on the final one. For each step between neighboring points the
// block forms the Metropolis rates up and down and folds them into one
// forward and one backward effective rate. On the point marked last one
// result leaves on the output channel (o_valid/i_ready): both rates in
// unsigned Q1.32, or o_single_point with zero rates for a one-point path.
// The configuration channel (i_cfg_valid/o_cfg_ready, always ready) writes
// inv_kt; write it only while the block is idle.
// A first point clears the path state; a flat step sets both rates to one;
// an underflowing step zeroes the uphill rate; an exponential step sums the
// series of exp(-f), f the fraction of delta*inv_kt, then applies exp(-1)
// n times (n < 32, the integer part). Each of the 23 divided terms is a
// multiply, a divider start, a divider run (3 quotient bits per cycle) and a
// step to take the quotient; folding into earlier steps adds two divisions.
// One point is worked at a time; a queue (two entries by default) takes
// further points. After reset inv_kt holds 37 C, the path state is cleared.
// A stalled receiver holds the result register; the back end then waits.
`default_nettype none
`include "assert_macros.svh"
module path_transition_rate_combiner #(
    parameter int QUEUE_DEPTH = ptrc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [ptrc_pkg::ENERGY_W-1:0] i_energy,
    input  wire logic                                 i_first,
    input  wire logic                                 i_last,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [ptrc_pkg::RATE_W-1:0]               o_rate_up,
    output logic [ptrc_pkg::RATE_W-1:0]               o_rate_down,
    output logic                                      o_single_point,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [ptrc_pkg::KT_W-1:0]            i_cfg_data
);
    logic [ptrc_pkg::KT_W-1:0] r_inv_kt;
    logic                      w_q_push;
    logic                      w_q_pop;
    logic                      w_q_valid;
    logic                      w_q_full;
    ptrc_pkg::t_item           w_push_item;
    ptrc_pkg::t_item           w_pop_item;
    ptrc_pkg::t_div_req        w_div_req;
    ptrc_pkg::t_div_rsp        w_div_rsp;

    // Configuration register: always ready, hold until the next transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_kt <= ptrc_pkg::INV_KT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_inv_kt <= i_cfg_data;
        end
    end

    // Front end: classify points and form the energy step.
    ptrc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_energy (i_energy),
        .i_first  (i_first),
        .i_last   (i_last),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_item (w_push_item)
    );

    // Decouple the two sides so each may stall on its own.
    ptrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_pop_item)
    );

    // Back end: exponential, rate folding, result register.
    ptrc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_inv_kt       (r_inv_kt),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_pop_item),
        .o_q_pop        (w_q_pop),
        .o_div_req      (w_div_req),
        .i_div_rsp      (w_div_rsp),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_rate_up      (o_rate_up),
        .o_rate_down    (o_rate_down),
        .o_single_point (o_single_point)
    );

    // Shared divider for series terms and rate folding.
    ptrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    `ASSERT_IMPLY(a_single_zero, i_clk, i_rst_n, o_valid && o_single_point, (o_rate_up == '0) && (o_rate_down == '0))
    `ASSERT_IMPLY(a_rate_bound, i_clk, i_rst_n, o_valid, !(o_rate_up[32] && (|o_rate_up[31:0])) && !(o_rate_down[32] && (|o_rate_down[31:0])))
    `ASSERT_IMPLY(a_pop_valid, i_clk, i_rst_n, w_q_pop, w_q_valid)
    `ASSERT_NEXT(a_div_latency, i_clk, i_rst_n, w_div_req.start, !w_div_rsp.done)
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the path transition rate combiner.
`default_nettype none

typedef struct {
    logic [32:0] up;
    logic [32:0] down;
    logic        single;
} t_path_rates;

// Predicts the path rates and checks them against what the block delivers.
class path_rate_scoreboard;
    logic [31:0]        inv_kt;
    logic signed [18:0] prev_energy;
    logic [32:0]        acc_up;
    logic [32:0]        acc_down;
    bit                 has_step;
    t_path_rates        pending[$];
    int                 errors;
    int                 results;

    function void clear_path();
        inv_kt      = ptrc_pkg::INV_KT_RESET;
        prev_energy = '0;
        acc_up      = '0;
        acc_down    = '0;
        has_step    = 0;
        errors      = 0;
        results     = 0;
    endfunction

    // Alternating Taylor series of exp(-r), r in [0,1), Q32 in and out.
    function logic [63:0] series_exp(logic [63:0] r);
        logic [63:0] term;
        logic [63:0] even;
        logic [63:0] odd;
        term = 64'h1_0000_0000;
        even = term;
        odd  = '0;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * r) >> 32) / 64'(k);
            if (k % 2 == 1) odd = odd + term;
            else            even = even + term;
        end
        return (even >= odd) ? even - odd : 64'd0;
    endfunction

    // Metropolis rate for a move from one energy to another.
    function logic [32:0] hop_rate(logic signed [18:0] from_e, logic signed [18:0] to_e);
        int          delta;
        logic [63:0] x;
        logic [63:0] half;
        logic [63:0] e_minus_one;
        logic [63:0] res;
        delta = int'(to_e) - int'(from_e);
        if (delta <= 0) return 33'h1_0000_0000;
        x = 64'(delta) * 64'(inv_kt);
        if ((x >> 32) >= 32) return '0;
        half        = series_exp(64'h8000_0000);
        e_minus_one = (half * half) >> 32;
        res         = series_exp(x & 64'hFFFF_FFFF);
        for (int n = 0; n < int'(x >> 32); n++)
            res = (res * e_minus_one) >> 32;
        return res[32:0];
    endfunction

    function logic [32:0] scaled_quotient(logic [32:0] a, logic [32:0] b, logic [33:0] d);
        logic [127:0] q;
        q = (128'(a) * 128'(b)) / 128'(d);
        return q[32:0];
    endfunction

    // Fold an accepted point into the path; queue a result on the last point.
    function void note_point(logic signed [18:0] energy, bit first, bit last);
        logic [32:0] ru;
        logic [32:0] rd;
        logic [33:0] divisor;
        t_path_rates r;
        if (first) begin
            has_step = 0;
            acc_up   = '0;
            acc_down = '0;
        end else begin
            ru = hop_rate(prev_energy, energy);
            rd = hop_rate(energy, prev_energy);
            if (!has_step) begin
                acc_up   = ru;
                acc_down = rd;
                has_step = 1;
            end else begin
                divisor = 34'(acc_down) + 34'(ru);
                if (divisor == 0) begin
                    acc_up   = '0;
                    acc_down = '0;
                end else begin
                    // both updates use the old backward rate
                    acc_up   = scaled_quotient(acc_up, ru, divisor);
                    acc_down = scaled_quotient(acc_down, rd, divisor);
                end
            end
        end
        prev_energy = energy;
        if (last) begin
            r.up     = has_step ? acc_up : '0;
            r.down   = has_step ? acc_down : '0;
            r.single = !has_step;
            pending  = {pending, r};
        end
    endfunction

    function void check_result(logic [32:0] up, logic [32:0] down, logic single);
        t_path_rates exp_r;
        results++;
        if (pending.size() == 0) begin
            $error("result with no path waiting: up %h down %h single %b", up, down, single);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (up !== exp_r.up) begin
            $error("rate_up expected %h actual %h", exp_r.up, up);
            errors++;
        end
        if (down !== exp_r.down) begin
            $error("rate_down expected %h actual %h", exp_r.down, down);
            errors++;
        end
        if (single !== exp_r.single) begin
            $error("single_point expected %b actual %b", exp_r.single, single);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 1_500_000;
    // worst case: two queued steps plus one in flight
    localparam int DRAIN_CYCLES = 1500;
    localparam int HOLD_CYCLES  = 3000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic signed [18:0] i_energy = '0;
    logic               i_first = 0;
    logic               i_last = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic [32:0]        o_rate_up;
    logic [32:0]        o_rate_down;
    logic               o_single_point;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_data = '0;

    path_rate_scoreboard rates = new();

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stall_request;
    int  points_sent;
    int  cfg_writes;
    int  cycles;
    logic signed [18:0] walk_energy;
    bit  path_closed;

    path_transition_rate_combiner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_energy       (i_energy),
        .i_first        (i_first),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_rate_up      (o_rate_up),
        .o_rate_down    (o_rate_down),
        .o_single_point (o_single_point),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: check every result transfer, then pick the next ready.
    // A stall request holds ready low for a long stretch so the queue fills.
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            rates.check_result(o_rate_up, o_rate_down, o_single_point);
        if (stall_request) begin
            stall_request = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one point; hold valid and payload until the transfer happens.
    task automatic send_point(logic signed [18:0] energy, bit first, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid  <= 1'b1;
        i_energy <= energy;
        i_first  <= first;
        i_last   <= last;
        do @(posedge i_clk); while (!o_ready);
        rates.note_point(energy, first, last);
        points_sent++;
        walk_energy = energy;
        path_closed = last;
    endtask

    // Drain the block so that inv_kt is written only while it is idle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (rates.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_inv_kt(logic [31:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rates.inv_kt = value;
        cfg_writes++;
    endtask

    function automatic logic signed [18:0] random_step(logic signed [18:0] from_e);
        int span;
        case ($urandom_range(3))
            0: span = 4;
            1: span = 40;
            2: span = 400;
            default: span = 4000;
        endcase
        return from_e + 19'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Random paths: mostly well formed, plus single points, continuations and noise.
    task automatic random_paths(int count);
        int stop_at;
        int len;
        int pick;
        stop_at = points_sent + count;
        while (points_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_point(19'($urandom), 1, 1);
            end else if (pick < 12) begin
                send_point(19'($urandom), $urandom_range(1), $urandom_range(1));
            end else if (pick < 18) begin
                // carry on from the previous point without a new first
                len = $urandom_range(1, 3);
                for (int i = 1; i <= len; i++)
                    send_point(random_step(walk_energy), 0, i == len);
            end else begin
                len = $urandom_range(2, 6);
                send_point(19'($urandom), 1, 0);
                for (int i = 2; i <= len; i++)
                    send_point(random_step(walk_energy), 0, i == len);
            end
        end
        // close the path so the last result marks an idle block
        if (!path_closed) send_point(random_step(walk_energy), 0, 1);
    endtask

    initial begin
        cycles        = 0;
        stall_request = 0;
        points_sent   = 0;
        cfg_writes    = 0;
        walk_energy   = '0;
        path_closed   = 1;
        rates.clear_path();
        send_idle_pct = 21;
        recv_idle_pct = 52;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: continue from the reset energy without a first point.
        send_point(19'sd100, 0, 0);
        send_point(19'sd50, 0, 1);
        // one-point path
        send_point(19'sd7, 1, 1);
        // energy extremes both ways, then a zero divisor
        send_point(19'sd262143, 1, 0);
        send_point(-19'sd262144, 0, 0);
        send_point(19'sd262143, 0, 1);
        // flat steps and small moves
        send_point(-19'sd5, 1, 0);
        send_point(-19'sd5, 0, 0);
        send_point(19'sd30, 0, 0);
        send_point(19'sd12, 0, 0);
        send_point(19'sd700, 0, 1);
        // extend the finished path again
        send_point(19'sd650, 0, 1);
        send_point(-19'sd1, 1, 0);
        send_point(19'sd0, 0, 0);
        send_point(-19'sd2000, 0, 1);
        send_point(19'sd0, 1, 1);

        // Extremes of the temperature setting, then ordinary ones.
        write_inv_kt(32'hFFFF_FFFF);
        random_paths(90);
        write_inv_kt(32'h0000_0000);
        send_idle_pct = 52;
        recv_idle_pct = 21;
        random_paths(90);
        write_inv_kt($urandom);
        // receiver backs off for a long stretch while points keep coming
        stall_request = 1;
        random_paths(120);
        write_inv_kt(ptrc_pkg::INV_KT_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_paths(130);

        wait_idle();
        $display("covered %0d path points, %0d results, %0d inv_kt writes",
                 points_sent, rates.results, cfg_writes);
        $display("paths included single points, continuations, underflow and zero divisors");
        if (rates.errors == 0 && rates.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
